// ----- hw/rtl/drs_pkg.sv -----
// Shared types and constants for the delay running statistics block.
// No dependencies; compile first.
package drs_pkg;

   localparam int DELAY_BITS_DEFAULT = 32;
   localparam int SUM_BITS_DEFAULT   = 64;
   localparam int FIELD_BITS         = 32;
   localparam int COUNT_BITS         = 64;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OLD_MEAN,
      ST_LIMIT,
      ST_CLAMP,
      ST_REBUILD,
      ST_FIT,
      ST_ADD,
      ST_MEAN,
      ST_ERROR,
      ST_RESPOND
   } drs_state_type;

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } drs_op_type;

   typedef struct packed {
      logic       start;
      drs_op_type op;
   } drs_unit_ctl_type;

endpackage

// ----- hw/rtl/drs_channels.sv -----
// Valid/ready channel interfaces for sample words and statistics words.
// Depends on drs_pkg.
interface drs_req_if import drs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] delay_ms;

   modport source (output valid, output delay_ms, input ready);
   modport sink   (input valid, input delay_ms, output ready);
endinterface

interface drs_rsp_if import drs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] average_delay;
   logic [FIELD_BITS-1:0] minimum_delay;
   logic [FIELD_BITS-1:0] maximum_delay;
   logic [COUNT_BITS-1:0] samples_seen;
   logic                  status;

   modport source (output valid, output average_delay, output minimum_delay,
                   output maximum_delay, output samples_seen, output status,
                   input ready);
   modport sink   (input valid, input average_delay, input minimum_delay,
                   input maximum_delay, input samples_seen, input status,
                   output ready);
endinterface

// ----- hw/rtl/drs_serial_unit.sv -----
// Bit-serial divide / multiply unit on one shared adder, one bit per cycle.
// Depends on drs_pkg.
module drs_serial_unit import drs_pkg::*; #(
   parameter int SUM_BITS = SUM_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  drs_unit_ctl_type      ctl,
   input  logic [SUM_BITS-1:0]   opnd_a,
   input  logic [COUNT_BITS-1:0] opnd_b,
   output logic                  done,
   output logic [SUM_BITS-1:0]   result
);

   localparam int CNT_W = $clog2(SUM_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   drs_op_type            op_ff, op_in;
   logic [COUNT_BITS-1:0] b_ff, b_in;
   logic [COUNT_BITS:0]   work_ff, work_in;
   logic [SUM_BITS-1:0]   quo_ff, quo_in;

   logic [COUNT_BITS:0]   add_x, add_y;
   logic [COUNT_BITS+1:0] add_total;
   logic                  add_cin;

   always_comb begin
      if (op_ff == OP_DIV) begin
         add_x   = {work_ff[COUNT_BITS-1:0], quo_ff[SUM_BITS-1]};
         add_y   = ~{1'b0, b_ff};
         add_cin = 1'b1;
      end else begin
         add_x   = (COUNT_BITS+1)'({work_ff[SUM_BITS-2:0], 1'b0});
         add_y   = quo_ff[SUM_BITS-1] ? (COUNT_BITS+1)'(b_ff[SUM_BITS-1:0]) : '0;
         add_cin = 1'b0;
      end
      add_total = (COUNT_BITS+2)'(add_x) + (COUNT_BITS+2)'(add_y)
                + (COUNT_BITS+2)'(add_cin);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      b_in    = b_ff;
      work_in = work_ff;
      quo_in  = quo_ff;
      if (!busy_ff && ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(SUM_BITS);
         op_in   = ctl.op;
         b_in    = opnd_b;
         work_in = '0;
         quo_in  = opnd_a;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (op_ff == OP_DIV) begin
            work_in = add_total[COUNT_BITS+1] ? add_total[COUNT_BITS:0] : add_x;
            quo_in  = {quo_ff[SUM_BITS-2:0], add_total[COUNT_BITS+1]};
         end else begin
            work_in = (COUNT_BITS+1)'(add_total[SUM_BITS-1:0]);
            quo_in  = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      b_ff    <= b_in;
      work_ff <= work_in;
      quo_ff  <= quo_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_DIV) ? quo_ff : work_ff[SUM_BITS-1:0];

endmodule

// ----- hw/rtl/delay_running_statistics.sv -----
// Running mean, minimum and maximum of delay samples, with history rescale.
// Depends on drs_pkg, drs_channels and drs_serial_unit.
//
// One sample word in gives one statistics word out. The first sample after
// reset, or after an error, seeds every statistic straight from the sample. A normal
// sample adds to the sum and recomputes the mean with the bit-serial divide.
// When the sum would overflow or the count is full, the history is rescaled
// first: one divide for the old mean, one more for the count limit when the
// mean is nonzero, one multiply to rebuild the sum and one more per halving of
// the count. The block takes no sample word while it works; a finished
// statistics word waits in an output register and the next sample is taken
// meanwhile. Status 1 means the count collapsed to zero; the next sample
// seeds again.
module delay_running_statistics import drs_pkg::*; #(
   parameter int DELAY_BITS = DELAY_BITS_DEFAULT,
   parameter int SUM_BITS   = SUM_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   drs_req_if.sink   req_port,
   drs_rsp_if.source rsp_port
);

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_BITS-1:0] SUM_MAX_W = COUNT_BITS'(SUM_MAX);

   drs_state_type         state_ff, state_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [DELAY_BITS-1:0] mean_ff, mean_in;
   logic [DELAY_BITS-1:0] low_ff, low_in;
   logic [DELAY_BITS-1:0] high_ff, high_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;
   logic [SUM_BITS-1:0]   old_mean_ff, old_mean_in;
   logic [SUM_BITS-1:0]   limit_ff, limit_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] avg_ff, avg_in;
   logic [FIELD_BITS-1:0] min_ff, min_in;
   logic [FIELD_BITS-1:0] max_ff, max_in;
   logic [COUNT_BITS-1:0] seen_ff, seen_in;
   logic                  status_ff, status_in;
   logic                  rsp_status_ff, rsp_status_in;

   drs_unit_ctl_type      unit_ctl;
   logic [SUM_BITS-1:0]   unit_a;
   logic [COUNT_BITS-1:0] unit_b;
   logic                  unit_done;
   logic [SUM_BITS-1:0]   unit_result;

   logic [DELAY_BITS-1:0] sample;
   logic [COUNT_BITS-1:0] sample_w;
   logic                  fits_now;
   logic [SUM_BITS-1:0]   sum_added;
   logic [COUNT_BITS-1:0] count_inc;
   logic [COUNT_BITS-1:0] count_half;
   logic [COUNT_BITS-1:0] count_clamped;

   function automatic logic sample_fits(input logic [SUM_BITS-1:0] s,
                                        input logic [DELAY_BITS-1:0] dv);
      logic [COUNT_BITS-1:0] s_w;
      logic [COUNT_BITS-1:0] d_w;
      s_w = COUNT_BITS'(s);
      d_w = COUNT_BITS'(dv);
      return (d_w <= SUM_MAX_W) && (s_w <= SUM_MAX_W - d_w);
   endfunction

   drs_serial_unit #(
      .SUM_BITS (SUM_BITS)
   ) u_serial_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opnd_a (unit_a),
      .opnd_b (unit_b),
      .done   (unit_done),
      .result (unit_result)
   );

   assign sample        = DELAY_BITS'(COUNT_BITS'(req_port.delay_ms));
   assign sample_w      = COUNT_BITS'(sample);
   assign fits_now      = sample_fits(sum_ff, delay_ff);
   assign sum_added     = sum_ff + SUM_BITS'(COUNT_BITS'(delay_ff));
   assign count_inc     = count_ff + 1'b1;
   assign count_half    = count_ff >> 1;
   assign count_clamped = (old_mean_ff != '0 && count_ff > COUNT_BITS'(limit_ff)) ?
                          COUNT_BITS'(limit_ff) : count_ff;

   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      mean_in       = mean_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      delay_in      = delay_ff;
      old_mean_in   = old_mean_ff;
      limit_in      = limit_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      avg_in        = avg_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      seen_in       = seen_ff;
      rsp_status_in = rsp_status_ff;
      unit_ctl.start = 1'b0;
      unit_ctl.op    = OP_DIV;
      unit_a         = sum_ff;
      unit_b         = count_ff;
      req_port.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               delay_in = sample;
               if (count_ff == '0) begin
                  sum_in    = (sample_w > SUM_MAX_W) ? SUM_MAX : SUM_BITS'(sample_w);
                  count_in  = COUNT_BITS'(1);
                  mean_in   = sample;
                  low_in    = sample;
                  high_in   = sample;
                  status_in = STATUS_OK;
                  state_in  = ST_RESPOND;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!fits_now || count_ff == COUNT_MAX) begin
               unit_ctl.start = 1'b1;
               unit_ctl.op    = OP_DIV;
               state_in       = ST_OLD_MEAN;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_OLD_MEAN: begin
            if (unit_done) begin
               old_mean_in = unit_result;
               count_in    = count_half + 1'b1;
               if (unit_result != '0) begin
                  unit_ctl.start = 1'b1;
                  unit_ctl.op    = OP_DIV;
                  unit_a         = SUM_MAX;
                  unit_b         = COUNT_BITS'(unit_result);
                  state_in       = ST_LIMIT;
               end else begin
                  state_in = ST_CLAMP;
               end
            end
         end
         ST_LIMIT: begin
            if (unit_done) begin
               limit_in = unit_result;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            count_in = count_clamped;
            if (count_clamped == '0) begin
               state_in = ST_ERROR;
            end else begin
               unit_ctl.start = 1'b1;
               unit_ctl.op    = OP_MUL;
               unit_a         = old_mean_ff;
               unit_b         = count_clamped;
               state_in       = ST_REBUILD;
            end
         end
         ST_REBUILD: begin
            if (unit_done) begin
               sum_in   = unit_result;
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (fits_now) begin
               state_in = ST_ADD;
            end else begin
               count_in = count_half;
               if (count_half == '0) begin
                  state_in = ST_ERROR;
               end else begin
                  unit_ctl.start = 1'b1;
                  unit_ctl.op    = OP_MUL;
                  unit_a         = old_mean_ff;
                  unit_b         = count_half;
                  state_in       = ST_REBUILD;
               end
            end
         end
         ST_ADD: begin
            sum_in   = sum_added;
            count_in = count_inc;
            if (count_inc == '0) begin
               state_in = ST_ERROR;
            end else begin
               unit_ctl.start = 1'b1;
               unit_ctl.op    = OP_DIV;
               unit_a         = sum_added;
               unit_b         = count_inc;
               state_in       = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (unit_done) begin
               mean_in   = DELAY_BITS'(COUNT_BITS'(unit_result));
               low_in    = (delay_ff < low_ff) ? delay_ff : low_ff;
               high_in   = (delay_ff > high_ff) ? delay_ff : high_ff;
               status_in = STATUS_OK;
               state_in  = ST_RESPOND;
            end
         end
         ST_ERROR: begin
            status_in = STATUS_ERROR;
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               avg_in        = FIELD_BITS'(COUNT_BITS'(mean_ff));
               min_in        = FIELD_BITS'(COUNT_BITS'(low_ff));
               max_in        = FIELD_BITS'(COUNT_BITS'(high_ff));
               seen_in       = count_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      delay_ff      <= delay_in;
      old_mean_ff   <= old_mean_in;
      limit_ff      <= limit_in;
      avg_ff        <= avg_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      seen_ff       <= seen_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.average_delay = avg_ff;
   assign rsp_port.minimum_delay = min_ff;
   assign rsp_port.maximum_delay = max_ff;
   assign rsp_port.samples_seen  = seen_ff;
   assign rsp_port.status        = rsp_status_ff;

endmodule

// ----- hw/rtl/drs_checker.sv -----
// Port-level checks for delay_running_statistics, attached by bind.
// Depends on drs_pkg and the top level's channel ports.
module drs_checker import drs_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [FIELD_BITS-1:0] rsp_average_delay,
   input logic [FIELD_BITS-1:0] rsp_minimum_delay,
   input logic [FIELD_BITS-1:0] rsp_maximum_delay,
   input logic [COUNT_BITS-1:0] rsp_samples_seen,
   input logic                  rsp_status
);

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample word taken while a sample is in work");

   a_error_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ERROR |-> rsp_samples_seen == '0)
      else $error("error status with nonzero count");

   a_ok_nonzero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_samples_seen != '0)
      else $error("ok status with zero count");

   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_minimum_delay <= rsp_maximum_delay)
      else $error("minimum above maximum");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average_delay)
         && $stable(rsp_samples_seen) && $stable(rsp_status))
      else $error("statistics word dropped or changed while stalled");

endmodule

bind delay_running_statistics drs_checker u_drs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_average_delay (rsp_port.average_delay),
   .rsp_minimum_delay (rsp_port.minimum_delay),
   .rsp_maximum_delay (rsp_port.maximum_delay),
   .rsp_samples_seen  (rsp_port.samples_seen),
   .rsp_status        (rsp_port.status)
);

// ----- tb/tb.sv -----
// Self-checking bench for delay_running_statistics: drives sample words, predicts each
// statistics word in a scoreboard class and checks every field on arrival.
// Depends on drs_pkg, drs_channels and delay_running_statistics.
module tb;
   import drs_pkg::*;

   localparam int DELAY_W = 32;
   localparam int SUM_W = 64;
   localparam logic [63:0] DELAY_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DELAY_W);
   localparam logic [63:0] SUM_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SUM_W);
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int DRAIN_CYCLES = 40 * (SUM_W + 2);

   typedef struct packed {
      logic [FIELD_BITS-1:0] average_delay;
      logic [FIELD_BITS-1:0] minimum_delay;
      logic [FIELD_BITS-1:0] maximum_delay;
      logic [COUNT_BITS-1:0] samples_seen;
      logic                  status;
   } stats_word_type;

   class delay_stats_board;
      logic [63:0] total = '0;
      logic [63:0] sample_count = '0;
      logic [63:0] last_sample = '0;
      logic [63:0] mean = '0;
      logic [63:0] low = '0;
      logic [63:0] high = '0;
      stats_word_type expected_stats[$];
      int samples_in = 0;
      int checked = 0;
      int rescales = 0;
      int collapses = 0;
      int wrong = 0;

      function bit room_for(logic [63:0] sum_val, logic [63:0] d);
         return d <= SUM_LIMIT && sum_val <= SUM_LIMIT - d;
      endfunction

      function void note_sample(logic [DELAY_W-1:0] sample_in);
         logic [63:0] d;
         logic [63:0] old_mean;
         bit collapsed;
         stats_word_type w;
         d = 64'(sample_in) & DELAY_MASK;
         collapsed = 0;
         samples_in++;
         if (sample_count == 0) begin
            total = (d > SUM_LIMIT) ? SUM_LIMIT : d;
            sample_count = 1;
            last_sample = d;
            mean = d;
            low = d;
            high = d;
         end else begin
            if (!room_for(total, d) || sample_count == COUNT_MAX) begin
               rescales++;
               old_mean = total / sample_count;
               sample_count = (sample_count >> 1) + 1;
               if (old_mean != 0 && sample_count > SUM_LIMIT / old_mean)
                  sample_count = SUM_LIMIT / old_mean;
               if (sample_count == 0) begin
                  collapsed = 1;
               end else begin
                  total = old_mean * sample_count;
                  while (!collapsed && !room_for(total, d)) begin
                     sample_count = sample_count >> 1;
                     if (sample_count == 0) collapsed = 1;
                     else total = old_mean * sample_count;
                  end
               end
            end
            if (!collapsed) begin
               total = total + d;
               sample_count = sample_count + 1;
               if (sample_count == 0) begin
                  collapsed = 1;
               end else begin
                  last_sample = d;
                  mean = (total / sample_count) & DELAY_MASK;
                  if (d < low) low = d;
                  if (d > high) high = d;
               end
            end
         end
         if (collapsed) collapses++;
         w.average_delay = mean[FIELD_BITS-1:0];
         w.minimum_delay = low[FIELD_BITS-1:0];
         w.maximum_delay = high[FIELD_BITS-1:0];
         w.samples_seen = sample_count;
         w.status = collapsed ? STATUS_ERROR : STATUS_OK;
         expected_stats.push_back(w);
      endfunction

      function void report(string field, logic [63:0] want, logic [63:0] got);
         wrong++;
         $display("%0t: %s wrong, expected %0d (0x%0h), got %0d (0x%0h)",
                  $time, field, want, want, got, got);
      endfunction

      function void check_stats(stats_word_type got);
         stats_word_type want;
         if (expected_stats.size() == 0) begin
            wrong++;
            $display("%0t: statistics word with none pending, expected nothing, got %0h",
                     $time, got);
            return;
         end
         want = expected_stats.pop_front();
         checked++;
         if (got.average_delay !== want.average_delay)
            report("average_delay", want.average_delay, got.average_delay);
         if (got.minimum_delay !== want.minimum_delay)
            report("minimum_delay", want.minimum_delay, got.minimum_delay);
         if (got.maximum_delay !== want.maximum_delay)
            report("maximum_delay", want.maximum_delay, got.maximum_delay);
         if (got.samples_seen !== want.samples_seen)
            report("samples_seen", want.samples_seen, got.samples_seen);
         if (got.status !== want.status)
            report("status", 64'(want.status), 64'(got.status));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit idle_on = 0;
   int hold_left = 0;
   int cycle_count = 0;
   delay_stats_board board = new();

   drs_req_if req_ch();
   drs_rsp_if rsp_ch();

   delay_running_statistics #(
      .DELAY_BITS(DELAY_W),
      .SUM_BITS(SUM_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_ch),
      .rsp_port(rsp_ch)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      stats_word_type seen;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_sample(req_ch.delay_ms);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.average_delay = rsp_ch.average_delay;
            seen.minimum_delay = rsp_ch.minimum_delay;
            seen.maximum_delay = rsp_ch.maximum_delay;
            seen.samples_seen = rsp_ch.samples_seen;
            seen.status = rsp_ch.status;
            board.check_stats(seen);
         end
      end
   end

   // stall the statistics side: random gaps while idle_on is set, plus long hold-offs when hold_left is loaded
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 0;
            hold_left = hold_left - 1;
         end else begin
            rsp_ch.ready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: run stopped at cycle limit with %0d words pending", $time,
               board.expected_stats.size());
      $display("delay_running_statistics: mismatch");
      $finish;
   end

   task automatic send_sample(logic [DELAY_W-1:0] d);
      if (idle_on && $urandom_range(99) < 20) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.delay_ms <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DELAY_W-1:0] pick_delay(int level);
      int unsigned r;
      logic [31:0] top;
      r = $urandom_range(99);
      top = (32'd1 << level) - 1;
      if (r < 78) return $urandom_range(0, top);
      if (r < 86) return $urandom_range(32'(SUM_LIMIT / 4), 32'(SUM_LIMIT));
      if (r < 94) return $urandom;
      case ($urandom_range(3))
         0: return '0;
         1: return 32'(SUM_LIMIT);
         2: return 32'(SUM_LIMIT + 1);
         default: return '1;
      endcase
   endfunction

   initial begin
      logic [DELAY_W-1:0] directed [18] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
         32'h0000_0001, 32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0000,
         32'h0000_0003, 32'h0000_0003, 32'h0000_0003, 32'h00FF_FFF0,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h0000_0002, 32'h0000_FFFF
      };
      int level;
      reset = 1;
      req_ch.valid = 0;
      req_ch.delay_ms = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i]) send_sample(directed[i]);
      for (int seg = 0; seg < 8; seg++) begin
         level = $urandom_range(2, SUM_W);
         idle_on = (seg != 3);
         for (int n = 0; n < 200; n++) begin
            if ((seg == 1 || seg == 5) && n == 50) hold_left = 400;
            send_sample(pick_delay(level));
         end
      end
      req_ch.valid <= 0;
      while (board.expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d samples and %0d statistics words checked,", board.samples_in,
               board.checked);
      $display("including %0d history rescales and %0d count collapses", board.rescales,
               board.collapses);
      if (board.wrong == 0 && board.expected_stats.size() == 0) begin
         $display("delay_running_statistics: match");
      end else begin
         $display("delay_running_statistics: mismatch");
      end
      $finish;
   end

endmodule
